/* hdl/hex_tag_record_matcher_assert.svh */
// assertion macros used by the matcher checker
// expects clk and rst_n in the scope where a macro is used
`ifndef HEX_TAG_RECORD_MATCHER_ASSERT_SVH
`define HEX_TAG_RECORD_MATCHER_ASSERT_SVH

// same-cycle implication
`define HTRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/htrm_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and decode functions of the hex tag record matcher
// no dependencies
package htrm_pkg;

    localparam int NAME_LEN_DEFAULT = 16;
    localparam int TAG_CHARS        = 10;
    localparam int TAG_BYTES        = 5;
    localparam int TAG_W            = 8 * TAG_BYTES;
    localparam int TAG_CNT_W        = $clog2(TAG_CHARS + 1);
    localparam int MAX_RUN          = 16;
    localparam int RUN_W            = $clog2(MAX_RUN + 1);
    localparam int IDX_W            = 4;

    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_END        = 8'h38;
    localparam logic [7:0] HEX_ALPHA_MIN = 8'd58;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       final_req;
    } stream_beat_t;

    typedef struct packed {
        logic             found;
        logic             name_present;
        logic [7:0]       name_byte;
        logic [IDX_W-1:0] name_index;
        logic             run_end;
    } answer_beat_t;

    typedef struct packed {
        logic [TAG_W-1:0] search_tag;
    } cfg_beat_t;

    typedef enum logic [2:0] {
        ST_SCAN,
        ST_ISSUE,
        ST_LOAD,
        ST_WAIT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic process;
        logic start_run;
        logic rd_en;
        logic load_out;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic trigger;
        logic run_last;
    } dp_status_t;

    function automatic logic [7:0] hex_digit(input logic [7:0] v);
        return (v >= HEX_ALPHA_MIN) ? (v - HEX_ALPHA_OFS) : (v - HEX_DIGIT_OFS);
    endfunction

    function automatic logic [7:0] tag_byte(input logic [7:0] hi_char,
                                            input logic [7:0] lo_char);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_digit(hi_char);
        lo = hex_digit(lo_char);
        return {hi[3:0], 4'b0000} | lo;
    endfunction

endpackage

/* hdl/htrm_chan_if.sv */
`timescale 1ns / 1ps
// valid/ready channel carrying one payload beat
// payload type is set per instance from htrm_pkg
interface htrm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/htrm_ctrl.sv */
`timescale 1ns / 1ps
// controller of the matcher: scan, answer run sequencing, search done
// depends on htrm_pkg
module htrm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_valid,
    input  logic                stream_first,
    output logic                stream_ready,
    output logic                answer_valid,
    input  logic                answer_ready,
    input  htrm_pkg::dp_status_t status,
    output htrm_pkg::ctrl_cmd_t  cmd
);
    import htrm_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        stream_ready = 1'b0;
        answer_valid = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                stream_ready = 1'b1;
                if (stream_valid)
                begin
                    cmd.process = 1'b1;
                    if (status.trigger)
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_ISSUE;
                    end
                end
            end
            ST_DONE:
            begin
                // bytes are dropped until one marked first restarts the search
                stream_ready = 1'b1;
                if (stream_valid && stream_first)
                begin
                    cmd.process = 1'b1;
                    if (status.trigger)
                    begin
                        cmd.start_run = 1'b1;
                        state_next    = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_ISSUE:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_out = 1'b1;
                state_next   = ST_WAIT;
            end
            ST_WAIT:
            begin
                answer_valid = 1'b1;
                if (answer_ready)
                begin
                    if (status.run_last)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase
    end
endmodule

/* hdl/htrm_datapath.sv */
`timescale 1ns / 1ps
// datapath of the matcher: tag capture and decode, name memory, answer register
// depends on htrm_pkg
module htrm_datapath #(
    parameter int NAME_LEN = htrm_pkg::NAME_LEN_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  htrm_pkg::ctrl_cmd_t    cmd,
    input  htrm_pkg::stream_beat_t beat,
    input  logic                   cfg_we,
    input  htrm_pkg::cfg_beat_t    cfg_data,
    output htrm_pkg::dp_status_t   status,
    output htrm_pkg::answer_beat_t answer_beat
);
    import htrm_pkg::*;

    localparam int ADDR_W = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int LEN_W  = $clog2(NAME_LEN + 1);

    logic [TAG_W-1:0]     search_tag_reg;
    logic                 in_name_reg;
    logic                 in_name_next;
    logic                 cap_active_reg;
    logic                 cap_active_next;
    logic [TAG_CNT_W-1:0] cap_count_reg;
    logic [TAG_CNT_W-1:0] cap_count_next;
    logic [7:0]           tag_chars_reg [TAG_CHARS];
    logic [7:0]           tag_chars_next [TAG_CHARS];
    logic [LEN_W-1:0]     name_len_reg;
    logic [LEN_W-1:0]     name_len_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [IDX_W-1:0]     run_idx_reg;
    logic [7:0]           rd_data_reg;
    answer_beat_t         answer_reg;

    logic [7:0] name_mem [NAME_LEN];

    // state as seen by this beat, after a first beat clears everything
    logic                 in_name_cur;
    logic                 cap_active_cur;
    logic [TAG_CNT_W-1:0] cap_count_cur;
    logic [7:0]           tag_cur [TAG_CHARS];
    logic [LEN_W-1:0]     name_len_cur;
    logic                 hit_cur;
    logic                 tag_match;
    logic                 name_we;
    logic [ADDR_W-1:0]    name_waddr;
    logic [RUN_W-1:0]     run_len;
    logic                 run_last;

    always_comb
    begin
        in_name_cur    = beat.first ? 1'b0 : in_name_reg;
        cap_active_cur = beat.first ? 1'b0 : cap_active_reg;
        cap_count_cur  = beat.first ? '0 : cap_count_reg;
        name_len_cur   = beat.first ? '0 : name_len_reg;
        hit_cur        = beat.first ? 1'b0 : hit_reg;
        for (int i = 0; i < TAG_CHARS; i++)
        begin
            tag_cur[i] = beat.first ? 8'h00 : tag_chars_reg[i];
        end
    end

    always_comb
    begin
        tag_match = 1'b1;
        for (int i = 0; i < TAG_BYTES; i++)
        begin
            if (tag_byte(tag_cur[2*i], tag_cur[2*i+1]) != search_tag_reg[8*i +: 8])
            begin
                tag_match = 1'b0;
            end
        end
    end

    assign name_waddr = ADDR_W'(name_len_cur);

    always_comb
    begin
        in_name_next    = in_name_reg;
        cap_active_next = cap_active_reg;
        cap_count_next  = cap_count_reg;
        name_len_next   = name_len_reg;
        hit_next        = hit_reg;
        tag_chars_next  = tag_chars_reg;
        name_we         = 1'b0;
        if (cmd.process)
        begin
            in_name_next    = in_name_cur;
            cap_active_next = cap_active_cur;
            cap_count_next  = cap_count_cur;
            name_len_next   = name_len_cur;
            hit_next        = hit_cur;
            tag_chars_next  = tag_cur;
            if (!in_name_cur)
            begin
                if (beat.data_byte == CH_STAR)
                begin
                    cap_active_next = 1'b1;
                    cap_count_next  = '0;
                end
                else if (beat.data_byte == CH_HASH)
                begin
                    cap_active_next = 1'b0;
                    cap_count_next  = '0;
                    in_name_next    = 1'b1;
                    if (tag_match)
                    begin
                        hit_next = 1'b1;
                    end
                end
                else if (cap_active_cur && (cap_count_cur < TAG_CNT_W'(TAG_CHARS)))
                begin
                    tag_chars_next[cap_count_cur] = beat.data_byte;
                    cap_count_next = cap_count_cur + TAG_CNT_W'(1);
                end
            end
            else
            begin
                if (beat.data_byte == CH_HASH)
                begin
                    cap_active_next = 1'b1;
                    cap_count_next  = '0;
                    name_len_next   = '0;
                end
                else if (beat.data_byte == CH_END)
                begin
                    // with a hit the answer goes out and the state is frozen
                    if (!hit_cur)
                    begin
                        cap_active_next = 1'b0;
                        cap_count_next  = '0;
                        in_name_next    = 1'b0;
                    end
                end
                else if (cap_active_cur && (name_len_cur < LEN_W'(NAME_LEN)))
                begin
                    name_we       = 1'b1;
                    name_len_next = name_len_cur + LEN_W'(1);
                end
            end
        end
    end

    assign status.trigger = (in_name_cur && (beat.data_byte == CH_END) && hit_cur)
                          || beat.final_req;

    always_comb
    begin
        if (int'(name_len_reg) > MAX_RUN)
        begin
            run_len = RUN_W'(MAX_RUN);
        end
        else
        begin
            run_len = RUN_W'(name_len_reg);
        end
        run_last = (run_len == '0) || ((RUN_W'(run_idx_reg) + RUN_W'(1)) == run_len);
    end

    assign status.run_last = run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_tag_reg <= '0;
            in_name_reg    <= 1'b0;
            cap_active_reg <= 1'b0;
            cap_count_reg  <= '0;
            name_len_reg   <= '0;
            hit_reg        <= 1'b0;
            run_idx_reg    <= '0;
            for (int i = 0; i < TAG_CHARS; i++)
            begin
                tag_chars_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                search_tag_reg <= cfg_data.search_tag;
            end
            in_name_reg    <= in_name_next;
            cap_active_reg <= cap_active_next;
            cap_count_reg  <= cap_count_next;
            name_len_reg   <= name_len_next;
            hit_reg        <= hit_next;
            tag_chars_reg  <= tag_chars_next;
            if (cmd.start_run)
            begin
                run_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                run_idx_reg <= run_idx_reg + IDX_W'(1);
            end
        end
    end

    // name memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[name_waddr] <= beat.data_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= name_mem[ADDR_W'(run_idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            answer_reg.found <= hit_reg;
            if (run_len == '0)
            begin
                answer_reg.name_present <= 1'b0;
                answer_reg.name_byte    <= 8'h00;
                answer_reg.name_index   <= '0;
                answer_reg.run_end      <= 1'b1;
            end
            else
            begin
                answer_reg.name_present <= 1'b1;
                answer_reg.name_byte    <= rd_data_reg;
                answer_reg.name_index   <= run_idx_reg;
                answer_reg.run_end      <= run_last;
            end
        end
    end

    assign answer_beat = answer_reg;
endmodule

/* hdl/hex_tag_record_matcher.sv */
`timescale 1ns / 1ps
// top level of the hex tag record matcher: controller plus datapath
// depends on htrm_pkg, htrm_chan_if, htrm_ctrl and htrm_datapath
// While scanning, the matcher takes one stream byte per clock; tag decode and
// compare happen in the cycle the '#' arrives. When a byte calls for the answer
// (an '8' after a hit, or final_req), the stream stalls and the answer goes out
// as one beat per name byte (a single beat for an empty name), each beat
// passing issue, load and wait states plus any back-pressure: the name memory's
// registered read port is stepped once per beat. After the run the block keeps
// taking bytes but ignores them until one marked first starts a new search,
// which is processed in that same cycle. No clearing pass follows reset. The
// search tag may be written at any idle time; the cfg channel is always ready.
module hex_tag_record_matcher #(
    parameter int NAME_LEN = htrm_pkg::NAME_LEN_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    htrm_chan_if.sink    stream,
    htrm_chan_if.source  answer,
    htrm_chan_if.sink    cfg
);
    import htrm_pkg::*;

    ctrl_cmd_t    cmd;
    dp_status_t   status;
    stream_beat_t stream_beat;
    cfg_beat_t    cfg_beat;
    answer_beat_t answer_beat;

    assign stream_beat    = stream.payload;
    assign cfg_beat       = cfg.payload;
    assign cfg.ready      = 1'b1;
    assign answer.payload = answer_beat;

    htrm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream.valid),
        .stream_first (stream_beat.first),
        .stream_ready (stream.ready),
        .answer_valid (answer.valid),
        .answer_ready (answer.ready),
        .status       (status),
        .cmd          (cmd)
    );

    htrm_datapath #(
        .NAME_LEN (NAME_LEN)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .beat        (stream_beat),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg_beat),
        .status      (status),
        .answer_beat (answer_beat)
    );
endmodule

/* hdl/htrm_checker.sv */
`timescale 1ns / 1ps
// port-level checker for the hex tag record matcher, bound to the top level
// depends on htrm_pkg and hex_tag_record_matcher_assert.svh
`include "hex_tag_record_matcher_assert.svh"

module htrm_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   stream_valid,
    input logic                   stream_ready,
    input logic                   stream_first,
    input logic                   stream_final,
    input logic                   answer_valid,
    input logic                   answer_ready,
    input htrm_pkg::answer_beat_t answer_payload
);
    import htrm_pkg::*;

    // a stalled answer beat holds
    `HTRM_ASSERT_NEXT(a_answer_hold, answer_valid && !answer_ready, answer_valid && $stable(answer_payload), "answer beat changed while stalled")

    // the stream is closed for the whole answer run
    `HTRM_ASSERT_NOW(a_no_scan_in_run, answer_valid, !stream_ready, "stream open during answer run")

    // a first byte with final_req always starts a run
    `HTRM_ASSERT_NEXT(a_final_starts_run, stream_valid && stream_ready && stream_first && stream_final, !stream_ready && !answer_valid, "final byte did not start a run")

    // an empty name is a single closing beat
    `HTRM_ASSERT_NOW(a_empty_name, answer_valid && !answer_payload.name_present, answer_payload.run_end && (answer_payload.name_index == '0) && (answer_payload.name_byte == 8'h00), "empty name beat malformed")
endmodule

bind hex_tag_record_matcher htrm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .stream_valid   (stream.valid),
    .stream_ready   (stream.ready),
    .stream_first   (stream.payload.first),
    .stream_final   (stream.payload.final_req),
    .answer_valid   (answer.valid),
    .answer_ready   (answer.ready),
    .answer_payload (answer.payload)
);

/* sim/tb_hex_tag_record_matcher.sv */
`timescale 1ns / 1ps
// self-checking testbench for hex_tag_record_matcher: random record streams under random stalls
// depends on htrm_pkg, htrm_chan_if and the matcher rtl; answers are predicted per stream beat
module tb_hex_tag_record_matcher;
    import htrm_pkg::*;

    localparam int IDLE_PCT           = 23;
    localparam int ITEM_TARGET        = 310;
    localparam int SEARCHES_PER_PHASE = 3;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int SETTLE_CYCLES      = 8;
    localparam int NAME_CAP           = NAME_LEN_DEFAULT;

    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    htrm_chan_if #(.payload_t(stream_beat_t)) stream_if ();
    htrm_chan_if #(.payload_t(answer_beat_t)) answer_if ();
    htrm_chan_if #(.payload_t(cfg_beat_t))    cfg_if ();

    hex_tag_record_matcher u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .answer (answer_if),
        .cfg    (cfg_if)
    );

    // mirror of the matcher state
    logic [TAG_W-1:0] tag_mirror;
    logic             in_name;
    logic             capture_on;
    int unsigned      capture_cnt;
    logic [7:0]       tag_text [TAG_CHARS];
    logic [7:0]       name_text [NAME_CAP];
    int unsigned      name_len;
    logic             tag_hit_seen;
    logic             answer_sent;

    stream_beat_t stream_backlog [$];
    answer_beat_t pending_answers [$];

    logic             stream_fire = 1'b0;
    logic             cfg_fire = 1'b0;
    logic             no_idle = 1'b0;
    logic             first_pending = 1'b0;
    int               beats_queued = 0;
    int               beats_accepted = 0;
    int               mismatch_count = 0;
    int               idle_cycles = 0;
    logic [TAG_W-1:0] cur_tag = '0;

    function automatic void clear_search_state();
        in_name      = 1'b0;
        capture_on   = 1'b0;
        capture_cnt  = 0;
        foreach (tag_text[i]) tag_text[i] = 8'h00;
        foreach (name_text[i]) name_text[i] = 8'h00;
        name_len     = 0;
        tag_hit_seen = 1'b0;
        answer_sent  = 1'b0;
    endfunction

    function automatic logic [7:0] char_value(input logic [7:0] c);
        return (c >= 8'd58) ? 8'(c - 8'd55) : 8'(c - 8'd48);
    endfunction

    function automatic logic tag_text_matches();
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] b;
        for (int i = 0; i < TAG_BYTES; i++)
        begin
            hi = char_value(tag_text[2 * i]);
            lo = char_value(tag_text[2 * i + 1]);
            b  = {hi[3:0], 4'h0} | lo;
            if (b != tag_mirror[8 * i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void queue_answer_run();
        int unsigned  n;
        answer_beat_t a;
        answer_sent = 1'b1;
        n = (name_len > MAX_RUN) ? MAX_RUN : name_len;
        if (n == 0)
        begin
            a.found        = tag_hit_seen;
            a.name_present = 1'b0;
            a.name_byte    = 8'h00;
            a.name_index   = '0;
            a.run_end      = 1'b1;
            pending_answers.push_back(a);
        end
        else
        begin
            for (int unsigned k = 0; k < n; k++)
            begin
                a.found        = tag_hit_seen;
                a.name_present = 1'b1;
                a.name_byte    = name_text[k];
                a.name_index   = IDX_W'(k);
                a.run_end      = (k + 1 == n);
                pending_answers.push_back(a);
            end
        end
    endfunction

    function automatic void track_stream_byte(input stream_beat_t b);
        logic [7:0] v;
        v = b.data_byte;
        if (b.first)
            clear_search_state();
        if (answer_sent)
            return;
        if (!in_name)
        begin
            if (v == CH_STAR)
            begin
                capture_on  = 1'b1;
                capture_cnt = 0;
            end
            else if (v == CH_HASH)
            begin
                capture_on  = 1'b0;
                capture_cnt = 0;
                in_name     = 1'b1;
                if (tag_text_matches())
                    tag_hit_seen = 1'b1;
            end
            else if (capture_on && capture_cnt < TAG_CHARS)
            begin
                tag_text[capture_cnt] = v;
                capture_cnt++;
            end
        end
        else
        begin
            if (v == CH_HASH)
            begin
                capture_on  = 1'b1;
                capture_cnt = 0;
                name_len    = 0;
            end
            else if (v == CH_END)
            begin
                if (tag_hit_seen)
                begin
                    queue_answer_run();
                    return;
                end
                capture_on  = 1'b0;
                capture_cnt = 0;
                in_name     = 1'b0;
            end
            else if (capture_on && name_len < NAME_CAP)
            begin
                name_text[name_len] = v;
                name_len++;
            end
        end
        if (b.final_req)
            queue_answer_run();
    endfunction

    function automatic void check_answer(input answer_beat_t got);
        answer_beat_t want;
        if (pending_answers.size() == 0)
        begin
            $error("answer beat with nothing expected: %0h", got);
            mismatch_count++;
            return;
        end
        want = pending_answers.pop_front();
        if (got.found !== want.found)
        begin
            $error("found: expected %0h, actual %0h", want.found, got.found);
            mismatch_count++;
        end
        if (got.name_present !== want.name_present)
        begin
            $error("name_present: expected %0h, actual %0h", want.name_present, got.name_present);
            mismatch_count++;
        end
        if (got.name_byte !== want.name_byte)
        begin
            $error("name_byte: expected %0h, actual %0h", want.name_byte, got.name_byte);
            mismatch_count++;
        end
        if (got.name_index !== want.name_index)
        begin
            $error("name_index: expected %0h, actual %0h", want.name_index, got.name_index);
            mismatch_count++;
        end
        if (got.run_end !== want.run_end)
        begin
            $error("run_end: expected %0h, actual %0h", want.run_end, got.run_end);
            mismatch_count++;
        end
    endfunction

    // sample everything at the rising edge
    always @(posedge clk)
    begin
        stream_fire <= stream_if.valid && stream_if.ready;
        cfg_fire    <= cfg_if.valid && cfg_if.ready;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
                tag_mirror = cfg_if.payload.search_tag;
            if (stream_if.valid && stream_if.ready)
            begin
                track_stream_byte(stream_if.payload);
                beats_accepted++;
            end
            if (answer_if.valid && answer_if.ready)
                check_answer(answer_if.payload);
            if ((stream_if.valid && stream_if.ready) || (answer_if.valid && answer_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stream driver: next beat once the current one has gone
    always @(negedge clk)
    begin
        if (rst_n && (stream_fire || !stream_if.valid))
        begin
            if (stream_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                stream_if.valid   <= 1'b1;
                stream_if.payload <= stream_backlog.pop_front();
            end
            else
            begin
                stream_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        answer_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        do
            r = 8'($urandom_range(0, 255));
        while (r == a || r == b);
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    task automatic queue_beat(input logic [7:0] data, input logic fin);
        stream_beat_t b;
        b.data_byte = data;
        b.first     = first_pending;
        b.final_req = fin;
        first_pending = 1'b0;
        stream_backlog.push_back(b);
        beats_queued++;
    endtask

    // variant: 0 plain, 1 short tag, 2 extra characters, 3 junk before the star
    task automatic queue_tag(input logic [TAG_W-1:0] tag, input int variant);
        int         nchar;
        logic [3:0] nib;
        if (variant == 3)
            repeat ($urandom_range(1, 3)) queue_beat(rand_byte_except(CH_STAR, CH_HASH), 1'b0);
        queue_beat(CH_STAR, 1'b0);
        nchar = (variant == 1) ? $urandom_range(0, TAG_CHARS - 1) : TAG_CHARS;
        for (int i = 0; i < nchar; i++)
        begin
            nib = 4'(tag >> (8 * (i / 2) + ((i % 2 == 0) ? 4 : 0)));
            queue_beat(hex_char(nib), 1'b0);
        end
        if (variant == 2)
            repeat ($urandom_range(1, 4)) queue_beat(rand_byte_except(CH_STAR, CH_HASH), 1'b0);
        queue_beat(CH_HASH, 1'b0);
    endtask

    task automatic queue_random_search();
        logic [TAG_W-1:0] tag;
        int               sel;
        int               variant;
        int               len;
        first_pending = 1'b1;
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 8))
                queue_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            queue_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    tag = cur_tag;
                else if (sel < 60)
                    tag = cur_tag ^ (40'h1 << $urandom_range(0, TAG_W - 1));
                else
                    tag = {8'($urandom), $urandom};
                sel = $urandom_range(0, 99);
                variant = (sel < 70) ? 0 : (sel < 80) ? 1 : (sel < 90) ? 2 : 3;
                sel = $urandom_range(0, 99);
                len = (sel < 80) ? $urandom_range(0, 5) :
                      (sel < 95) ? $urandom_range(6, 15) : $urandom_range(16, 20);
                queue_tag(tag, variant);
                queue_beat(CH_HASH, 1'b0);
                repeat (len) queue_beat(rand_byte_except(CH_HASH, CH_END), 1'b0);
                queue_beat(CH_END, $urandom_range(0, 19) == 0);
            end
            // mostly closed by a final beat, now and then left open for the next first
            if ($urandom_range(0, 19) != 0)
                queue_beat(8'($urandom_range(0, 255)), 1'b1);
            repeat ($urandom_range(0, 2))
                queue_beat(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);
        end
    endtask

    task automatic write_search_tag(input logic [TAG_W-1:0] value);
        @(negedge clk);
        cfg_if.valid             <= 1'b1;
        cfg_if.payload.search_tag <= value;
        do
            @(negedge clk);
        while (!cfg_fire);
        cfg_if.valid <= 1'b0;
        cur_tag = value;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (beats_accepted != beats_queued || pending_answers.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase_no;
        logic [TAG_W-1:0] next_tag;

        rst_n             = 1'b0;
        stream_if.valid   = 1'b0;
        stream_if.payload = '0;
        answer_if.ready   = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = '0;
        tag_mirror        = '0;
        clear_search_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all-zero tag characters decode to this tag, so a bare '#' hits
        write_search_tag(40'hD0D0D0D0D0);

        // hit on a short tag right after first, two-byte name, then an ignored byte
        first_pending = 1'b1;
        queue_beat(CH_HASH, 1'b0);
        queue_beat(CH_HASH, 1'b0);
        queue_beat(8'h00, 1'b0);
        queue_beat(8'hFF, 1'b0);
        queue_beat(CH_END, 1'b0);
        queue_beat(8'h37, 1'b1);

        // byte outside capture, eleven characters, miss, kept name, stale short tag
        first_pending = 1'b1;
        queue_beat(8'h35, 1'b0);
        queue_beat(CH_STAR, 1'b0);
        for (int i = 0; i < 11; i++)
            queue_beat((i < 10) ? 8'(8'h30 + i) : 8'h41, 1'b0);
        queue_beat(CH_HASH, 1'b0);
        queue_beat(CH_HASH, 1'b0);
        queue_beat(8'h51, 1'b0);
        queue_beat(CH_END, 1'b0);
        queue_beat(CH_HASH, 1'b1);

        // hit with an empty name
        first_pending = 1'b1;
        queue_beat(CH_HASH, 1'b0);
        queue_beat(CH_END, 1'b0);

        // overlong name, hit and final on the same end byte
        first_pending = 1'b1;
        queue_beat(CH_HASH, 1'b0);
        queue_beat(CH_HASH, 1'b0);
        repeat (NAME_CAP + 1) queue_beat(rand_byte_except(CH_HASH, CH_END), 1'b0);
        queue_beat(CH_END, 1'b1);
        wait_idle();

        phase_no = 0;
        while (beats_queued < ITEM_TARGET)
        begin
            case (phase_no % 4)
                0: next_tag = '1;
                1: next_tag = '0;
                default: next_tag = {8'($urandom), $urandom};
            endcase
            write_search_tag(next_tag);
            no_idle = (phase_no == 1);
            for (int s = 0; s < SEARCHES_PER_PHASE && beats_queued < ITEM_TARGET; s++)
                queue_random_search();
            wait_idle();
            no_idle = 1'b0;
            phase_no++;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* hex_tag_record_matcher.f */
+incdir+hdl
hdl/htrm_pkg.sv
hdl/htrm_chan_if.sv
hdl/htrm_ctrl.sv
hdl/htrm_datapath.sv
hdl/hex_tag_record_matcher.sv
hdl/htrm_checker.sv
sim/tb_hex_tag_record_matcher.sv
